FILE: hdl/ecpp_pkg.sv
// Package for the ECP parallel port register block.
// Holds the opcodes, register indexes, mode bits and FIFO sizing.
`default_nettype none
package ecpp_pkg;
    localparam int FifoDepth = 16;
    localparam int PtrW = $clog2(FifoDepth);

    typedef enum logic [1:0] {
        OP_WRITE = 2'd0,
        OP_READ  = 2'd1,
        OP_TICK  = 2'd2,
        OP_NONE  = 2'd3
    } opcode_t;

    localparam logic [3:0] REG_DATA    = 4'd0;
    localparam logic [3:0] REG_STATUS  = 4'd1;
    localparam logic [3:0] REG_CONTROL = 4'd2;
    localparam logic [3:0] REG_EPPA    = 4'd3;
    localparam logic [3:0] REG_EPPD0   = 4'd4;
    localparam logic [3:0] REG_EPPD1   = 4'd5;
    localparam logic [3:0] REG_EPPD2   = 4'd6;
    localparam logic [3:0] REG_EPPD3   = 4'd7;
    localparam logic [3:0] REG_FIFO    = 4'd8;
    localparam logic [3:0] REG_CFGB    = 4'd9;
    localparam logic [3:0] REG_ECR     = 4'd10;
    localparam logic [3:0] REG_DDIR    = 4'd12;
    localparam logic [3:0] REG_SDIR    = 4'd13;
    localparam logic [3:0] REG_CDIR    = 4'd14;
    localparam logic [3:0] REG_FEAT    = 4'd15;

    localparam logic CFG_MODE    = 1'b0;
    localparam logic CFG_FEATURE = 1'b1;

    function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        r = (p == PtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
        return r;
    endfunction

    function automatic logic [PtrW-1:0] ptr_dec(input logic [PtrW-1:0] p);
        logic [PtrW-1:0] r;
        r = (p == '0) ? PtrW'(FifoDepth - 1) : p - 1'b1;
        return r;
    endfunction
endpackage
`default_nettype wire

FILE: hdl/ecp_parallel_port_registers_core.sv
// Top level of the ECP parallel port register block.
// Uses ecpp_pkg; the FIFO store is held in this module.
//
// One word is taken per clock while the input is not stalled: each register
// access or poll tick is decoded and applied straight from the input ports
// into the state and result registers, so its result appears in the cycle
// after acceptance. The input stalls only while a result waits on a
// stalled output, during a configuration write and during the restart cycle
// that follows it or the release of reset. The 16-entry FIFO is a register
// array read and written in the same update. A configuration write stores the
// new power-on mode or feature defaults and restarts the register set on the
// next cycle.
`default_nettype none
module ecp_parallel_port_registers_core (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       cfg_write,
    input  wire logic       cfg_index,
    input  wire logic [7:0] cfg_data,
    input  wire logic       in_valid,
    output logic            in_stall,
    input  wire logic [1:0] opcode,
    input  wire logic [3:0] reg_select,
    input  wire logic [7:0] write_data,
    input  wire logic [7:0] data_pins,
    input  wire logic [4:0] status_pins,
    input  wire logic [3:0] control_pins,
    input  wire logic       epp_ready,
    output logic            out_valid,
    input  wire logic       out_stall,
    output logic [7:0]      read_data,
    output logic [7:0]      data_drive,
    output logic [7:0]      data_enable,
    output logic [3:0]      control_drive,
    output logic [3:0]      control_enable,
    output logic [4:0]      status_drive,
    output logic [4:0]      status_enable
);
    import ecpp_pkg::*;

    logic [2:0] mode_cfg_reg;
    logic [7:0] feat_cfg_reg;
    logic       restart_reg;

    logic [7:0] dl_reg, dc_reg, ecr_reg, oh_reg, tm_reg, fb_reg;
    logic [7:0] ddir_reg, dout_reg;
    logic [3:0] cout_reg, cdir_reg;
    logic [4:0] sdir_reg, sout_reg;
    logic [PtrW-1:0] rp_reg, wp_reg;
    logic [8:0] fifo_mem [FifoDepth];

    logic [7:0] dl_n, dc_n, ecr_n, oh_n, tm_n, fb_n, ddir_n, dout_n, rd_n;
    logic [3:0] cout_n, cdir_n;
    logic [4:0] sdir_n, sout_n;
    logic [PtrW-1:0] rp_n, wp_n;
    logic       fw_en;
    logic [PtrW-1:0] fw_addr;
    logic [8:0] fw_data;

    logic       take;
    logic       in_valid_reg;
    logic [7:0] rd_reg;

    assign in_stall = cfg_write || restart_reg || (out_valid && out_stall);
    assign take = in_valid && !in_stall;

    always_comb
    begin
        logic [7:0] b, t, dcl;
        logic [4:0] s;
        logic       direct, busy, ack, put, get, stop;
        logic [8:0] putw, getw;
        logic [2:0] m;
        dl_n = dl_reg; dc_n = dc_reg; ecr_n = ecr_reg; oh_n = oh_reg;
        tm_n = tm_reg; fb_n = fb_reg; ddir_n = ddir_reg; dout_n = dout_reg;
        cout_n = cout_reg; cdir_n = cdir_reg; sdir_n = sdir_reg; sout_n = sout_reg;
        rp_n = rp_reg; wp_n = wp_reg; rd_n = 8'hFF;
        fw_en = 1'b0; fw_addr = wp_reg; fw_data = '0;
        b = write_data; t = '0; s = '0; m = '0; dcl = '0;
        direct = fb_reg[6]; busy = status_pins[4]; ack = status_pins[3];
        put = 1'b0; get = 1'b0; putw = '0; stop = 1'b0;
        getw = ecr_reg[0] ? fifo_mem[ptr_dec(rp_reg)] : fifo_mem[rp_reg];
        unique case (opcode_t'(opcode))
            OP_WRITE:
            begin
                unique case (reg_select)
                    REG_DATA:
                    begin
                        if ((oh_reg & 8'h4C) != 0)
                        begin
                            put = 1'b1; putw = {1'b0, b};
                        end
                        else
                        begin
                            dl_n = b;
                            if (!dc_reg[5])
                            begin
                                dout_n = b;
                                if (fb_reg[0]) ddir_n = ~b;
                            end
                        end
                    end
                    REG_STATUS:
                    begin
                        if (oh_reg[4] && !b[0]) tm_n = {tm_reg[7:1], 1'b0};
                        s = b[7:3];
                        if (!direct) s = (s ^ 5'h10) | ~sdir_reg;
                        sout_n = s;
                    end
                    REG_CONTROL:
                    begin
                        t = b | 8'hC0;
                        if ((oh_reg & 8'h05) != 0) t = t & 8'hDF;
                        dc_n = t;
                        if (!direct)
                        begin
                            if (t[5] != dc_reg[5])
                            begin
                                if (t[5])
                                begin
                                    ddir_n = 8'h00; dout_n = 8'hFF;
                                end
                                else
                                begin
                                    dout_n = dl_reg;
                                    ddir_n = fb_reg[0] ? ~dl_reg : 8'hFF;
                                end
                            end
                            t = t ^ 8'h0B;
                        end
                        cout_n = t[3:0];
                        if (fb_reg[2]) cdir_n = ~t[3:0];
                    end
                    REG_EPPA, REG_EPPD0, REG_EPPD1, REG_EPPD2, REG_EPPD3:
                    begin
                        dout_n = b;
                        if (busy || !epp_ready) tm_n = tm_reg | 8'h01;
                    end
                    REG_FIFO:
                    begin
                        if ((oh_reg & 8'h4C) != 0)
                        begin
                            put = 1'b1; putw = {1'b1, b};
                        end
                    end
                    REG_ECR:
                    begin
                        m = b[7:5];
                        ecr_n = (b & 8'hF8) | 8'h05;
                        oh_n = 8'(1) << m;
                        tm_n = (m == 3'd4) ? 8'hFE : 8'hFF;
                        if ((m == 3'd0 || m == 3'd2) && dc_reg[5])
                        begin
                            dc_n = dc_reg & 8'hDF;
                            dout_n = dl_reg;
                            ddir_n = fb_reg[0] ? ~dl_reg : 8'hFF;
                        end
                        rp_n = '0; wp_n = '0;
                    end
                    REG_DDIR: ddir_n = b;
                    REG_SDIR:
                    begin
                        sdir_n = b[7:3];
                        if (!direct) sout_n = sout_reg | ~b[7:3];
                    end
                    REG_CDIR: cdir_n = b[3:0];
                    REG_FEAT:
                    begin
                        t = b & 8'h45;
                        fb_n = t;
                        if (!t[6])
                        begin
                            if ((t[0] != fb_reg[0]) && !dc_reg[5])
                                ddir_n = t[0] ? ~dout_reg : 8'hFF;
                            if (t[2] != fb_reg[2])
                                cdir_n = t[2] ? ~cout_reg : 4'hF;
                            if (fb_reg[6])
                            begin
                                if (dc_reg[5])
                                begin
                                    ddir_n = 8'h00; dout_n = 8'hFF;
                                end
                                else
                                begin
                                    dout_n = dl_reg;
                                    ddir_n = t[0] ? ~dl_reg : 8'hFF;
                                end
                                sdir_n = '0; sout_n = 5'h1F;
                                dcl = dc_reg ^ 8'h0B;
                                cout_n = dcl[3:0]; cdir_n = 4'hF;
                            end
                        end
                    end
                    default: ;
                endcase
            end
            OP_READ:
            begin
                unique case (reg_select)
                    REG_DATA:
                    begin
                        if ((oh_reg & 8'h4C) != 0)
                        begin
                            get = 1'b1; rd_n = getw[7:0];
                        end
                        else rd_n = data_pins;
                    end
                    REG_STATUS:
                    begin
                        t = {status_pins, 3'b111};
                        if (!direct) t = t ^ 8'h80;
                        rd_n = t & tm_reg;
                    end
                    REG_CONTROL:
                    begin
                        t = {4'h0, ((oh_reg & 8'h4C) != 0) ? cout_reg : control_pins};
                        if (!direct) t = t ^ 8'h0B;
                        rd_n = t | (dc_reg & 8'hF0);
                    end
                    REG_EPPA, REG_EPPD0, REG_EPPD1, REG_EPPD2, REG_EPPD3:
                    begin
                        rd_n = data_pins;
                        if (busy || !epp_ready) tm_n = tm_reg | 8'h01;
                    end
                    REG_FIFO:
                    begin
                        if ((oh_reg & 8'hCC) == 0) rd_n = 8'hFF;
                        else if (oh_reg[7]) rd_n = 8'h10;
                        else
                        begin
                            get = 1'b1; rd_n = getw[7:0];
                        end
                    end
                    REG_CFGB: rd_n = oh_reg[7] ? 8'h00 : 8'hFF;
                    REG_ECR:  rd_n = ecr_reg;
                    REG_DDIR: rd_n = ddir_reg;
                    REG_SDIR: rd_n = {sdir_reg, 3'b000};
                    REG_CDIR: rd_n = {4'h0, cdir_reg};
                    REG_FEAT: rd_n = fb_reg;
                    default:  rd_n = 8'hFF;
                endcase
            end
            OP_TICK:
            begin
                if (oh_reg[2])
                begin
                    if (!ecr_reg[0] && !busy)
                    begin
                        get = 1'b1;
                        dout_n = getw[7:0];
                        cout_n = cout_reg | 4'h1;
                    end
                end
                else if (oh_reg[3])
                begin
                    if (dc_reg[5])
                    begin
                        if (!ecr_reg[1])
                        begin
                            if (!cout_reg[1])
                            begin
                                if (ack) stop = 1'b1;
                                else cout_n = cout_reg | 4'h2;
                            end
                            if (!stop && ack)
                            begin
                                put = 1'b1; putw = {busy, data_pins};
                                cout_n = cout_n & 4'hD;
                            end
                        end
                    end
                    else
                    begin
                        if (cout_reg[0])
                        begin
                            if (ecr_reg[0] || busy) stop = 1'b1;
                            else
                            begin
                                get = 1'b1;
                                dout_n = getw[7:0];
                                cout_n = {cout_reg[3:2], getw[8], 1'b0};
                            end
                        end
                        if (!stop && busy) cout_n = cout_n | 4'h1;
                    end
                end
            end
            default: ;
        endcase
        if (put && !ecr_reg[1])
        begin
            fw_en = 1'b1; fw_data = putw;
            wp_n = ptr_inc(wp_reg);
            ecr_n = {ecr_reg[7:2], (ptr_inc(wp_reg) == rp_reg), 1'b0};
        end
        if (get && !ecr_reg[0])
        begin
            rp_n = ptr_inc(rp_reg);
            ecr_n = {ecr_reg[7:2], 1'b0, (ptr_inc(rp_reg) == wp_reg)};
        end
    end

    always_ff @(posedge clk)
    begin
        if (take && fw_en) fifo_mem[fw_addr] <= fw_data;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_cfg_reg <= 3'd1; feat_cfg_reg <= 8'h00; restart_reg <= 1'b1;
            in_valid_reg <= 1'b0;
            dl_reg <= '0; dc_reg <= '0; ecr_reg <= '0; oh_reg <= '0; tm_reg <= '0;
            fb_reg <= '0; ddir_reg <= '0; dout_reg <= '0; cout_reg <= '0;
            cdir_reg <= '0; sdir_reg <= '0; sout_reg <= '0; rp_reg <= '0;
            wp_reg <= '0; rd_reg <= '0;
        end
        else if (cfg_write || restart_reg)
        begin
            restart_reg <= 1'b0;
            in_valid_reg <= 1'b0;
            if (cfg_write)
            begin
                if (cfg_index == CFG_MODE) mode_cfg_reg <= cfg_data[2:0];
                else feat_cfg_reg <= cfg_data;
                restart_reg <= 1'b1;
            end
            else
            begin
                fb_reg <= feat_cfg_reg & 8'h45;
                dl_reg <= '0;
                dc_reg <= 8'hCC;
                dout_reg <= '0;
                ddir_reg <= feat_cfg_reg[0] ? 8'hFF : 8'hFF;
                sdir_reg <= '0; sout_reg <= 5'h1F;
                cout_reg <= 4'h7; cdir_reg <= 4'hF;
                ecr_reg <= {mode_cfg_reg, 5'h05};
                oh_reg <= 8'(1) << mode_cfg_reg;
                tm_reg <= (mode_cfg_reg == 3'd4) ? 8'hFE : 8'hFF;
                rp_reg <= '0; wp_reg <= '0;
            end
        end
        else
        begin
            if (out_valid && !out_stall) in_valid_reg <= 1'b0;
            if (take)
            begin
                in_valid_reg <= 1'b1;
                dl_reg <= dl_n; dc_reg <= dc_n; ecr_reg <= ecr_n; oh_reg <= oh_n;
                tm_reg <= tm_n; fb_reg <= fb_n; ddir_reg <= ddir_n; dout_reg <= dout_n;
                cout_reg <= cout_n; cdir_reg <= cdir_n; sdir_reg <= sdir_n;
                sout_reg <= sout_n; rp_reg <= rp_n; wp_reg <= wp_n; rd_reg <= rd_n;
            end
        end
    end

    assign out_valid      = in_valid_reg;
    assign read_data      = rd_reg;
    assign data_drive     = dout_reg;
    assign data_enable    = ddir_reg;
    assign control_drive  = cout_reg;
    assign control_enable = cdir_reg;
    assign status_drive   = sout_reg;
    assign status_enable  = sdir_reg;
endmodule
`default_nettype wire

FILE: tb/sv/ecpp_checker.sv
`timescale 1ns / 1ps
// Checker for ecp_parallel_port_registers_core: predicts every result word
// from the accepted input words and compares it, reporting every field on a mismatch.
// Depends on ecpp_pkg for opcodes, register indexes and FIFO sizing.
module ecpp_checker
    import ecpp_pkg::*;
(
    input  logic       clk,
    input  logic       rst_n,
    input  logic       cfg_write,
    input  logic       cfg_index,
    input  logic [7:0] cfg_data,
    input  logic       in_valid,
    input  logic       in_stall,
    input  logic [1:0] opcode,
    input  logic [3:0] reg_select,
    input  logic [7:0] write_data,
    input  logic [7:0] data_pins,
    input  logic [4:0] status_pins,
    input  logic [3:0] control_pins,
    input  logic       epp_ready,
    input  logic       out_valid,
    input  logic       out_stall,
    input  logic [7:0] read_data,
    input  logic [7:0] data_drive,
    input  logic [7:0] data_enable,
    input  logic [3:0] control_drive,
    input  logic [3:0] control_enable,
    input  logic [4:0] status_drive,
    input  logic [4:0] status_enable,
    output int         mismatch_count,
    output int         words_pending
);
    localparam logic [7:0] FIFO_MODES = 8'h4C;
    localparam logic [7:0] SPP_MODES  = 8'h05;
    localparam logic [7:0] ANY_FIFO   = 8'hCC;

    typedef struct packed {
        logic [7:0] rd;
        logic [7:0] dd;
        logic [7:0] de;
        logic [3:0] cd;
        logic [3:0] ce;
        logic [4:0] sd;
        logic [4:0] se;
    } port_word_t;

    port_word_t port_words_due[$];
    int         miscompares;

    logic [2:0] pon_mode;
    logic [7:0] feat_dflt;
    logic [7:0] dlatch, devctl, ecr, mode_oh, tmask, feat, ddir, dout;
    logic [3:0] cout, cdir;
    logic [4:0] sdir, sout;
    logic [8:0] fifo [FifoDepth];
    logic [PtrW-1:0] rptr, wptr;

    function automatic logic [PtrW-1:0] ptr_next(input logic [PtrW-1:0] p);
        return (p == PtrW'(FifoDepth - 1)) ? '0 : p + 1'b1;
    endfunction

    task automatic fifo_push(input logic [8:0] w);
        if (ecr[1])
            return;
        fifo[wptr] = w;
        wptr = ptr_next(wptr);
        ecr[0] = 1'b0;
        if (wptr == rptr)
            ecr[1] = 1'b1;
    endtask

    task automatic fifo_pop(output logic [8:0] w);
        if (ecr[0])
        begin
            w = fifo[(rptr == '0) ? PtrW'(FifoDepth - 1) : rptr - 1'b1];
            return;
        end
        w = fifo[rptr];
        rptr = ptr_next(rptr);
        ecr[1] = 1'b0;
        if (wptr == rptr)
            ecr[0] = 1'b1;
    endtask

    task automatic steer_data();
        if (devctl[5])
        begin
            ddir = 8'h00;
            dout = 8'hFF;
        end
        else
        begin
            dout = dlatch;
            ddir = feat[0] ? ~dlatch : 8'hFF;
        end
    endtask

    task automatic port_on();
        steer_data();
        sdir = 5'h00;
        sout = 5'h1F;
        cout = devctl[3:0] ^ 4'hB;
        cdir = 4'hF;
    endtask

    task automatic ecr_load(input logic [7:0] b);
        ecr = (b & 8'hF8) | 8'h05;
        mode_oh = 8'h01 << b[7:5];
        tmask = mode_oh[4] ? 8'hFE : 8'hFF;
        if ((mode_oh & SPP_MODES) != 0 && devctl[5])
        begin
            devctl[5] = 1'b0;
            steer_data();
        end
        rptr = '0;
        wptr = '0;
    endtask

    task automatic restart();
        for (int i = 0; i < FifoDepth; i++)
            fifo[i] = '0;
        feat = feat_dflt & 8'h45;
        dlatch = 8'h00;
        devctl = 8'hCC;
        port_on();
        ecr_load({pon_mode, 5'b0});
    endtask

    task automatic epp_cycle(input logic [4:0] sp, input logic rdy);
        if (sp[4] || !rdy)
            tmask[0] = 1'b1;
    endtask

    task automatic reg_store(input logic [3:0] sel, input logic [7:0] b,
                             input logic [4:0] sp, input logic rdy);
        logic       direct;
        logic [7:0] bb, t;
        logic [4:0] s;
        direct = feat[6];
        case (sel)
            REG_DATA:
                if ((mode_oh & FIFO_MODES) != 0)
                    fifo_push({1'b0, b});
                else
                begin
                    dlatch = b;
                    if (!devctl[5])
                    begin
                        dout = b;
                        if (feat[0])
                            ddir = ~b;
                    end
                end
            REG_STATUS:
            begin
                if (mode_oh[4] && !b[0])
                    tmask[0] = 1'b0;
                s = b[7:3];
                if (!direct)
                begin
                    s ^= 5'h10;
                    s |= ~sdir;
                end
                sout = s;
            end
            REG_CONTROL:
            begin
                bb = b | 8'hC0;
                if ((mode_oh & SPP_MODES) != 0)
                    bb[5] = 1'b0;
                t = bb ^ devctl;
                devctl = bb;
                if (!direct)
                begin
                    if (t[5])
                        steer_data();
                    bb ^= 8'h0B;
                end
                cout = bb[3:0];
                if (feat[2])
                    cdir = ~bb[3:0];
            end
            REG_EPPA, REG_EPPD0, REG_EPPD1, REG_EPPD2, REG_EPPD3:
            begin
                dout = b;
                epp_cycle(sp, rdy);
            end
            REG_FIFO:
                if ((mode_oh & FIFO_MODES) != 0)
                    fifo_push({1'b1, b});
            REG_ECR:
                ecr_load(b);
            REG_DDIR:
                ddir = b;
            REG_SDIR:
            begin
                sdir = b[7:3];
                if (!direct)
                    sout |= ~sdir;
            end
            REG_CDIR:
                cdir = b[3:0];
            REG_FEAT:
            begin
                bb = b & 8'h45;
                t = feat ^ bb;
                feat = bb;
                if (t[0] && !bb[6] && !devctl[5])
                    ddir = bb[0] ? ~dout : 8'hFF;
                if (t[2] && !bb[6])
                    cdir = bb[2] ? ~cout : 4'hF;
                if (t[6] && !bb[6])
                    port_on();
            end
            default:
                ;
        endcase
    endtask

    task automatic reg_fetch(input logic [3:0] sel, input logic [4:0] sp,
                             input logic [3:0] cp, input logic [7:0] dp,
                             input logic rdy, output logic [7:0] rd);
        logic       direct;
        logic [8:0] w;
        logic [7:0] t;
        logic [3:0] c4;
        direct = feat[6];
        case (sel)
            REG_DATA:
                if ((mode_oh & FIFO_MODES) != 0)
                begin
                    fifo_pop(w);
                    rd = w[7:0];
                end
                else
                    rd = dp;
            REG_STATUS:
            begin
                t = {sp, 3'b111};
                if (!direct)
                    t ^= 8'h80;
                rd = t & tmask;
            end
            REG_CONTROL:
            begin
                c4 = ((mode_oh & FIFO_MODES) != 0) ? cout : cp;
                if (!direct)
                    c4 ^= 4'hB;
                rd = {devctl[7:4], c4};
            end
            REG_EPPA, REG_EPPD0, REG_EPPD1, REG_EPPD2, REG_EPPD3:
            begin
                epp_cycle(sp, rdy);
                rd = dp;
            end
            REG_FIFO:
                if ((mode_oh & ANY_FIFO) == 0)
                    rd = 8'hFF;
                else if (mode_oh[7])
                    rd = 8'h10;
                else
                begin
                    fifo_pop(w);
                    rd = w[7:0];
                end
            REG_CFGB:
                rd = mode_oh[7] ? 8'h00 : 8'hFF;
            REG_ECR:
                rd = ecr;
            REG_DDIR:
                rd = ddir;
            REG_SDIR:
                rd = {sdir, 3'b000};
            REG_CDIR:
                rd = {4'h0, cdir};
            REG_FEAT:
                rd = feat;
            default:
                rd = 8'hFF;
        endcase
    endtask

    task automatic handshake_tick(input logic [4:0] sp, input logic [7:0] dp);
        logic       busy, ack, go;
        logic [8:0] w;
        busy = sp[4];
        ack = sp[3];
        go = 1'b1;
        if (mode_oh[2])
        begin
            if (!ecr[0] && !busy)
            begin
                fifo_pop(w);
                dout = w[7:0];
                cout[0] = 1'b1;
            end
        end
        else if (mode_oh[3])
        begin
            if (devctl[5])
            begin
                if (!ecr[1])
                begin
                    if (!cout[1])
                    begin
                        if (ack)
                            go = 1'b0;
                        else
                            cout[1] = 1'b1;
                    end
                    if (go && ack)
                    begin
                        fifo_push({busy, dp});
                        cout[1] = 1'b0;
                    end
                end
            end
            else
            begin
                if (cout[0])
                begin
                    if (ecr[0] || busy)
                        go = 1'b0;
                    else
                    begin
                        fifo_pop(w);
                        dout = w[7:0];
                        cout[1] = w[8];
                        cout[0] = 1'b0;
                    end
                end
                if (go && busy)
                    cout[0] = 1'b1;
            end
        end
    endtask

    task automatic predict_word();
        port_word_t e;
        e.rd = 8'hFF;
        case (opcode_t'(opcode))
            OP_WRITE: reg_store(reg_select, write_data, status_pins, epp_ready);
            OP_READ:  reg_fetch(reg_select, status_pins, control_pins, data_pins,
                                epp_ready, e.rd);
            OP_TICK:  handshake_tick(status_pins, data_pins);
            default:  ;
        endcase
        e.dd = dout;
        e.de = ddir;
        e.cd = cout;
        e.ce = cdir;
        e.sd = sout;
        e.se = sdir;
        port_words_due.push_back(e);
    endtask

    task automatic compare_word();
        port_word_t e, g;
        g = {read_data, data_drive, data_enable, control_drive, control_enable,
             status_drive, status_enable};
        if (port_words_due.size() == 0)
        begin
            miscompares++;
            if (miscompares <= 10)
                $display("unexpected result word %h at %0t", g, $time);
            return;
        end
        e = port_words_due.pop_front();
        if (g !== e)
        begin
            miscompares++;
            if (miscompares <= 10)
                $display({"mismatch at %0t: rd %h/%h dd %h/%h de %h/%h cd %h/%h ",
                          "ce %h/%h sd %h/%h se %h/%h (expected/actual)"}, $time,
                         e.rd, g.rd, e.dd, g.dd, e.de, g.de, e.cd, g.cd,
                         e.ce, g.ce, e.sd, g.sd, e.se, g.se);
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pon_mode = 3'd1;
            feat_dflt = 8'h00;
            restart();
            port_words_due.delete();
            miscompares = 0;
            mismatch_count <= 0;
            words_pending <= 0;
        end
        else
        begin
            if (out_valid && !out_stall)
                compare_word();
            if (cfg_write)
            begin
                if (cfg_index == CFG_MODE)
                    pon_mode = cfg_data[2:0];
                else
                    feat_dflt = cfg_data;
                restart();
            end
            if (in_valid && !in_stall)
                predict_word();
            mismatch_count <= miscompares;
            words_pending <= port_words_due.size();
        end
    end
endmodule

FILE: tb/sv/testbench.sv
`timescale 1ns / 1ps
// Top of the testbench for ecp_parallel_port_registers_core: drives register
// accesses and poll ticks over several power-on settings and idle patterns.
// Depends on ecpp_pkg and ecpp_checker, which predicts and compares results.
module testbench;
    import ecpp_pkg::*;

    logic       clk = 1'b0;
    logic       rst_n = 1'b0;
    logic       cfg_write = 1'b0;
    logic       cfg_index = 1'b0;
    logic [7:0] cfg_data = 8'h00;
    logic       in_valid = 1'b0;
    logic       in_stall;
    logic [1:0] opcode = OP_NONE;
    logic [3:0] reg_select = REG_DATA;
    logic [7:0] write_data = 8'h00;
    logic [7:0] data_pins = 8'h00;
    logic [4:0] status_pins = 5'h00;
    logic [3:0] control_pins = 4'h0;
    logic       epp_ready = 1'b0;
    logic       out_valid;
    logic       out_stall = 1'b0;
    logic [7:0] read_data, data_drive, data_enable;
    logic [3:0] control_drive, control_enable;
    logic [4:0] status_drive, status_enable;
    int         mismatch_count, words_pending;

    int   send_idle_pct = 0;
    int   recv_stall_pct = 0;
    logic hold_toggle = 1'b0;
    logic hold_seen = 1'b0;
    int   hold_left = 0;

    ecp_parallel_port_registers_core DUT (.*);
    ecpp_checker port_check (.*);

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    initial
    begin
        #3ms;
        $display("FAIL ecp_parallel_port_registers_core");
        $finish;
    end

    always @(posedge clk)
    begin
        if (hold_toggle != hold_seen)
        begin
            hold_seen <= hold_toggle;
            hold_left <= 300;
            out_stall <= 1'b1;
        end
        else if (hold_left > 0)
        begin
            hold_left <= hold_left - 1;
            out_stall <= 1'b1;
        end
        else
            out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
    end

    task automatic offer(input opcode_t op, input logic [3:0] sel, input logic [7:0] wd);
        while ($urandom_range(0, 99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        opcode <= op;
        reg_select <= sel;
        write_data <= wd;
        data_pins <= 8'($urandom);
        status_pins <= 5'($urandom);
        control_pins <= 4'($urandom);
        epp_ready <= 1'($urandom);
        in_valid <= 1'b1;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        @(posedge clk);
        while (words_pending != 0)
            @(posedge clk);
    endtask

    task automatic set_power_on(input logic [2:0] mode, input logic [7:0] feat);
        cfg_write <= 1'b1;
        cfg_index <= CFG_MODE;
        cfg_data <= {5'b0, mode};
        @(posedge clk);
        cfg_index <= CFG_FEATURE;
        cfg_data <= feat;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
    endtask

    task automatic random_word();
        int         r, k;
        opcode_t    op;
        logic [3:0] sel;
        logic [7:0] wd;
        r = $urandom_range(0, 99);
        op = (r < 45) ? OP_WRITE : (r < 78) ? OP_READ : (r < 97) ? OP_TICK : OP_NONE;
        k = $urandom_range(0, 9);
        wd = 8'($urandom);
        case (k)
            0, 1, 2: sel = REG_DATA;
            3, 4:    sel = REG_FIFO;
            5:       sel = REG_STATUS;
            6:       sel = REG_CONTROL;
            7:       sel = 4'($urandom);
            8:       sel = 4'($urandom_range(REG_EPPA, REG_EPPD3));
            default: sel = ($urandom_range(0, 99) < 40) ? REG_ECR
                                                        : 4'($urandom_range(REG_DDIR, REG_FEAT));
        endcase
        offer(op, sel, wd);
    endtask

    initial
    begin
        logic [2:0] modes [6] = '{3'd0, 3'd7, 3'd3, 3'd2, 3'd4, 3'd1};
        logic [7:0] feats [6] = '{8'hFF, 8'h00, 8'h45, 8'h01, 8'h04, 8'h40};
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        for (int ph = 0; ph < 7; ph++)
        begin
            if (ph > 0)
            begin
                drain();
                repeat (4) @(posedge clk);
                set_power_on(modes[ph-1], feats[ph-1]);
            end
            send_idle_pct = 0;
            recv_stall_pct = 0;
            // fill every FIFO entry once so that an empty read returns a written word
            offer(OP_WRITE, REG_ECR, 8'h40);
            for (int i = 0; i < 17; i++)
                offer(OP_WRITE, REG_FIFO, 8'($urandom));
            offer(OP_WRITE, REG_ECR, 8'($urandom));
            if (ph == 0)
            begin
                for (int r = 0; r < 16; r++)
                    offer(OP_READ, 4'(r), 8'h00);
                offer(OP_WRITE, REG_STATUS, 8'h00);
                offer(OP_WRITE, REG_CONTROL, 8'hFF);
                offer(OP_WRITE, REG_FEAT, 8'hFF);
                offer(OP_WRITE, REG_CFGB, 8'hFF);
                offer(OP_WRITE, 4'd11, 8'hFF);
                offer(OP_WRITE, REG_ECR, 8'h60);
                offer(OP_TICK, REG_DATA, 8'h00);
                offer(OP_READ, REG_FIFO, 8'h00);
                offer(OP_NONE, REG_DATA, 8'hFF);
            end
            for (int i = 0; i < 200; i++)
            begin
                case ((i / 50 + ph) % 4)
                    0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
                    1: begin send_idle_pct = 74; recv_stall_pct = 0;  end
                    2: begin send_idle_pct = 0;  recv_stall_pct = 74; end
                    default: begin send_idle_pct = 31; recv_stall_pct = 31; end
                endcase
                if (ph == 2 && i == 100)
                    hold_toggle <= ~hold_toggle;
                if (ph == 3 && i == 100)
                    drain();
                random_word();
            end
        end
        drain();
        repeat (10) @(posedge clk);
        if (mismatch_count == 0 && words_pending == 0)
            $display("PASS ecp_parallel_port_registers_core");
        else
            $display("FAIL ecp_parallel_port_registers_core");
        $finish;
    end
endmodule

FILE: sim.f
hdl/ecpp_pkg.sv
hdl/ecp_parallel_port_registers_core.sv
tb/sv/ecpp_checker.sv
tb/sv/testbench.sv
